FILE: src/fqlm_pkg.sv
// ----------------------------------------------------------------------------
// fqlm_pkg
// Shared constants, codes and word types of the per-key FIFO lock manager.
// ----------------------------------------------------------------------------
`default_nettype none

package fqlm_pkg;

  // sizing
  localparam int KEY_COUNT    = 64;
  localparam int QUEUE_DEPTH  = 16;
  localparam int CLIENT_COUNT = 256;

  localparam int KEY_W    = $clog2(KEY_COUNT);
  localparam int POS_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = POS_W + 1;
  localparam int CLIENT_W = $clog2(CLIENT_COUNT);
  localparam int SLOT_W   = KEY_W + POS_W;
  localparam int STATUS_W = 3;
  localparam int KEYS_W   = KEY_W + 1;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // request codes
  localparam logic FUNC_LOCK   = 1'b0;
  localparam logic FUNC_UNLOCK = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_KEY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd4;

  // register index, taken from paddr[2]
  localparam logic REG_LOCAL_CLIENT = 1'b0;
  localparam logic REG_KEYS_IN_USE  = 1'b1;

  localparam logic [KEYS_W-1:0] KEYS_IN_USE_RST = KEYS_W'(KEY_COUNT);

  typedef struct packed {
    logic                func;
    logic [CLIENT_W-1:0] client;
    logic [KEY_W-1:0]    key_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                local_granted;
    logic                local_released;
    logic                holder_valid;
    logic [CLIENT_W-1:0] holder_client;
    logic [CNT_W-1:0]    waiting_count;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_head;
    logic eval_head;
    logic eval_next;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic need_next;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/fqlm_regs.sv
// ----------------------------------------------------------------------------
// fqlm_regs
// APB-style configuration registers: local client id and keys in use.
// ----------------------------------------------------------------------------
`default_nettype none

module fqlm_regs
  import fqlm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic      [DATA_W-1:0]   prdata,
  output logic                     pready,
  output logic      [CLIENT_W-1:0] local_client_o,
  output logic      [KEYS_W-1:0]   keys_in_use_o
);

  logic [CLIENT_W-1:0] local_client_q;
  logic [KEYS_W-1:0]   keys_in_use_q;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_client_q <= '0;
      keys_in_use_q  <= KEYS_IN_USE_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_LOCAL_CLIENT: local_client_q <= pwdata[CLIENT_W-1:0];
        REG_KEYS_IN_USE:  keys_in_use_q  <= pwdata[KEYS_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_LOCAL_CLIENT: prdata = DATA_W'(local_client_q);
      REG_KEYS_IN_USE:  prdata = DATA_W'(keys_in_use_q);
      default:          prdata = '0;
    endcase
  end

  assign local_client_o = local_client_q;
  assign keys_in_use_o  = keys_in_use_q;

endmodule

`default_nettype wire

FILE: src/fqlm_ctrl.sv
// ----------------------------------------------------------------------------
// fqlm_ctrl
// Request sequencer: table lookup, holder read, optional new-head read.
// ----------------------------------------------------------------------------
`default_nettype none

module fqlm_ctrl
  import fqlm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_HEAD = 2'd2;
  localparam logic [1:0] S_NEXT = 2'd3;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_HEAD;
      end
      S_HEAD: begin
        if (sts_i.out_free) begin
          cmd_o.eval_head = 1'b1;
          state_d         = sts_i.need_next ? S_NEXT : S_IDLE;
        end
      end
      S_NEXT: begin
        if (sts_i.out_free) begin
          cmd_o.eval_next = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/fqlm_dp.sv
// ----------------------------------------------------------------------------
// fqlm_dp
// Datapath: queue table with valid bits, waiter store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fqlm_dp
  import fqlm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire req_t                in_data_i,
  input  wire logic [CLIENT_W-1:0] local_client_i,
  input  wire logic [KEYS_W-1:0]   keys_in_use_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output res_t                     out_data_o
);

  localparam int TBL_W = POS_W + CNT_W;

  // queue table: head and count per key, cleared by valid bits
  logic [TBL_W-1:0]     tbl_mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] tbl_vld_q;
  logic [TBL_W-1:0]     tbl_rd_q;
  logic                 tbl_rd_vld_q;
  logic                 tbl_wr_en;
  logic [TBL_W-1:0]     tbl_wr_data;

  // waiter store, one ring per key
  logic [CLIENT_W-1:0] st_mem [KEY_COUNT*QUEUE_DEPTH];
  logic [CLIENT_W-1:0] st_rd_q;
  logic                st_rd_en;
  logic [SLOT_W-1:0]   st_rd_addr;
  logic                st_wr_en;
  logic [SLOT_W-1:0]   st_wr_addr;

  req_t                req_q;
  res_t                out_q;
  logic                out_valid_q;
  res_t                res_head;
  res_t                res_next;
  logic                load;

  logic [POS_W-1:0]    head;
  logic [POS_W-1:0]    head_inc;
  logic [CNT_W-1:0]    cnt;
  logic                key_ok;
  logic                full;
  logic                lock_ok;
  logic                unlock_ok;
  logic                need_next;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
    end
  end

  // table valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q    <= '0;
      tbl_rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        tbl_rd_vld_q <= tbl_vld_q[in_data_i.key_id];
      end
      if (tbl_wr_en) begin
        tbl_vld_q[req_q.key_id] <= 1'b1;
      end
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tbl_rd_q <= tbl_mem[in_data_i.key_id];
    end
    if (tbl_wr_en) begin
      tbl_mem[req_q.key_id] <= tbl_wr_data;
    end
  end

  // decode of the looked-up queue
  assign head      = tbl_rd_vld_q ? tbl_rd_q[TBL_W-1:CNT_W] : '0;
  assign cnt       = tbl_rd_vld_q ? tbl_rd_q[CNT_W-1:0] : '0;
  assign head_inc  = head + POS_W'(1);
  assign key_ok    = ({1'b0, req_q.key_id} < keys_in_use_i);
  assign full      = (cnt >= CNT_W'(QUEUE_DEPTH));
  assign lock_ok   = key_ok & (req_q.func == FUNC_LOCK) & !full;
  assign unlock_ok = key_ok & (req_q.func == FUNC_UNLOCK) & (cnt != '0) &
                     (st_rd_q == req_q.client);
  assign need_next = unlock_ok & (cnt > CNT_W'(1));

  assign tbl_wr_en   = cmd_i.eval_head & (lock_ok | unlock_ok);
  assign tbl_wr_data = lock_ok ? {head, cnt + CNT_W'(1)} : {head_inc, cnt - CNT_W'(1)};

  // store ports: holder read, new-head read, tail append
  assign st_rd_en   = cmd_i.rd_head | (cmd_i.eval_head & need_next);
  assign st_rd_addr = {req_q.key_id, (cmd_i.rd_head ? head : head_inc)};
  assign st_wr_en   = cmd_i.eval_head & lock_ok;
  assign st_wr_addr = {req_q.key_id, head + cnt[POS_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (st_rd_en) begin
      st_rd_q <= st_mem[st_rd_addr];
    end
    if (st_wr_en) begin
      st_mem[st_wr_addr] <= req_q.client;
    end
  end

  // result after the holder read
  always_comb begin
    res_head = '0;
    if (!key_ok) begin
      res_head.status = ST_BAD_KEY;
    end else if (req_q.func == FUNC_LOCK) begin
      if (full) begin
        res_head.status        = ST_FULL;
        res_head.holder_valid  = 1'b1;
        res_head.holder_client = st_rd_q;
        res_head.waiting_count = cnt;
      end else begin
        res_head.status        = ST_OK;
        res_head.local_granted = (cnt == '0) & (req_q.client == local_client_i);
        res_head.holder_valid  = 1'b1;
        res_head.holder_client = (cnt == '0) ? req_q.client : st_rd_q;
        res_head.waiting_count = cnt + CNT_W'(1);
      end
    end else if (cnt == '0) begin
      res_head.status = ST_EMPTY;
    end else if (st_rd_q != req_q.client) begin
      res_head.status        = ST_MISMATCH;
      res_head.holder_valid  = 1'b1;
      res_head.holder_client = st_rd_q;
      res_head.waiting_count = cnt;
    end else begin
      // last entry popped, queue now empty
      res_head.status         = ST_OK;
      res_head.local_released = (req_q.client == local_client_i);
    end
  end

  // result after the new-head read
  always_comb begin
    res_next                = '0;
    res_next.status         = ST_OK;
    res_next.local_released = (req_q.client == local_client_i);
    res_next.local_granted  = (st_rd_q == local_client_i);
    res_next.holder_valid   = 1'b1;
    res_next.holder_client  = st_rd_q;
    res_next.waiting_count  = cnt - CNT_W'(1);
  end

  // output register
  assign load = (cmd_i.eval_head & !need_next) | cmd_i.eval_next;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= cmd_i.eval_next ? res_next : res_head;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.out_free  = !out_valid_q | out_ready_i;
  assign sts_o.need_next = need_next;

endmodule

`default_nettype wire

FILE: src/per_key_fifo_lock_manager.sv
// ----------------------------------------------------------------------------
// per_key_fifo_lock_manager
// FIFO-queued lock manager, one queue of waiting clients per lock key.
// ----------------------------------------------------------------------------
// usage:
//   in channel carries one request word (func, client, key_id); out channel
//   returns exactly one result word per request, in request order.
//   in_ready_o is high only while the sequencer is idle, so one request is
//   in flight at a time.
//   result: loaded into the output register after the table lookup and
//   holder read, and after a new-head read for an unlock that hands the
//   lock to a next waiter. A new request is accepted only after the last
//   is through, since the single read port of the waiter store (holder
//   read, then new-head read) sits behind the registered queue table lookup.
//   stall: the result word waits in the output register while the next
//   request is accepted and looked up; that request holds before its update
//   until the output register frees.
//   reset: all queues empty (per-key valid bits), local_client 0,
//   keys_in_use 64; no clearing pass, the block is ready at once.
//   config: registers at byte 0 (local_client) and 4 (keys_in_use), written
//   only while idle; this binds the user, the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module per_key_fifo_lock_manager
  import fqlm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire req_t              in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output res_t                   out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  logic [CLIENT_W-1:0] local_client;
  logic [KEYS_W-1:0]   keys_in_use;
  cmd_t                cmd;
  sts_t                sts;

  // configuration registers
  fqlm_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .local_client_o (local_client),
    .keys_in_use_o  (keys_in_use)
  );

  // sequencer
  fqlm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // queues and result
  fqlm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_data_i      (in_data_i),
    .local_client_i (local_client),
    .keys_in_use_i  (keys_in_use),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

endmodule

`default_nettype wire

FILE: src/fqlm_checker.sv
// ----------------------------------------------------------------------------
// fqlm_checker
// Port-level checks of the lock manager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fqlm_checker
  import fqlm_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire res_t out_data_o
);

  // one request in flight: ready drops right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // result word holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // holder present exactly when the queue is non-empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.holder_valid == (out_data_o.waiting_count != '0)))
    else $error("holder_valid disagrees with waiting_count");

  // failed requests never grant or release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      !out_data_o.local_granted && !out_data_o.local_released)
    else $error("grant or release flagged on a failed request");

  // bad key and empty unlock report an empty holder
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_BAD_KEY || out_data_o.status == ST_EMPTY) |->
      (out_data_o.holder_client == '0) && (out_data_o.waiting_count == '0))
    else $error("holder fields set on bad key or empty unlock");

endmodule

bind per_key_fifo_lock_manager fqlm_checker u_fqlm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-key FIFO lock manager. A directed table
// walks the corner cases (empty unlock, wrong owner, full queue, bad key,
// keys_in_use at its extremes), then random lock and unlock traffic runs
// under several register settings and idle patterns. Every result word is
// compared field by field with a typed row or a queue-per-key bench model.
// ----------------------------------------------------------------------------

module tb;
  import fqlm_pkg::*;

  // directed table row kinds
  typedef enum logic [1:0] {ROW_REQ, ROW_SET_LOCAL, ROW_SET_KEYS} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    req_t        req;
    int unsigned rep;
    logic [31:0] wdata;
    bit          typed;
    res_t        res;
  } row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  req_t              in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  res_t              out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  per_key_fifo_lock_manager u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // lock table model: ring of waiting clients per key
  logic [CLIENT_W-1:0] waiter_ring [KEY_COUNT][QUEUE_DEPTH];
  logic [POS_W-1:0]    ring_head   [KEY_COUNT];
  logic [CNT_W-1:0]    ring_len    [KEY_COUNT];
  logic [CLIENT_W-1:0] local_id;
  logic [KEYS_W-1:0]   keys_limit;

  res_t        due_results[$];
  row_t        dir_rows[$];
  int unsigned fail_cnt;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned lock_pct;
  int unsigned hold_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // apply one request to the lock table and return its result word
  function automatic res_t apply_request(req_t r);
    res_t             res;
    logic [CNT_W-1:0] n;
    logic [POS_W-1:0] pos;
    res = '0;
    if (r.key_id >= keys_limit) begin
      res.status = ST_BAD_KEY;
      return res;
    end
    n = ring_len[r.key_id];
    if (r.func == FUNC_LOCK) begin
      if (n >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = ring_head[r.key_id] + n[POS_W-1:0];
        waiter_ring[r.key_id][pos] = r.client;
        ring_len[r.key_id] = n + 1'b1;
        res.local_granted = (n == 0) && (r.client == local_id);
      end
    end else if (n == 0) begin
      res.status = ST_EMPTY;
      return res;
    end else if (waiter_ring[r.key_id][ring_head[r.key_id]] != r.client) begin
      res.status = ST_MISMATCH;
    end else begin
      res.local_released = (r.client == local_id);
      ring_head[r.key_id] = ring_head[r.key_id] + 1'b1;
      ring_len[r.key_id] = n - 1'b1;
      res.local_granted = (ring_len[r.key_id] != 0) &&
                          (waiter_ring[r.key_id][ring_head[r.key_id]] == local_id);
    end
    // holder view after the step
    res.holder_valid  = (ring_len[r.key_id] != 0);
    res.holder_client = res.holder_valid ?
                        waiter_ring[r.key_id][ring_head[r.key_id]] : '0;
    res.waiting_count = ring_len[r.key_id];
    return res;
  endfunction

  // random request, mostly on a few keys and mostly well-formed unlocks
  function automatic req_t draw_request();
    req_t        r;
    int unsigned span;
    span = (keys_limit == 0) ? 1 : ((keys_limit < 4) ? keys_limit : 4);
    r.key_id = ($urandom_range(99) < 10) ? KEY_W'($urandom_range(KEY_COUNT - 1))
                                         : KEY_W'($urandom_range(span - 1));
    r.func = ($urandom_range(99) < lock_pct) ? FUNC_LOCK : FUNC_UNLOCK;
    if (r.func == FUNC_UNLOCK && r.key_id < keys_limit &&
        ring_len[r.key_id] != 0 && $urandom_range(99) < 80) begin
      r.client = waiter_ring[r.key_id][ring_head[r.key_id]];
    end else begin
      case ($urandom_range(4))
        0: r.client = local_id;
        1: r.client = 8'hFF;
        2: r.client = 8'h00;
        3: r.client = 8'h5A;
        default: r.client = CLIENT_W'($urandom_range(CLIENT_COUNT - 1));
      endcase
    end
    return r;
  endfunction

  function automatic row_t req_row(logic f, logic [CLIENT_W-1:0] c,
                                   logic [KEY_W-1:0] k, int unsigned n);
    row_t w;
    w.kind = ROW_REQ;
    w.req = '{func: f, client: c, key_id: k};
    w.rep = n;
    w.wdata = '0;
    w.typed = 1'b0;
    w.res = '0;
    return w;
  endfunction

  function automatic row_t typed_row(logic f, logic [CLIENT_W-1:0] c,
                                     logic [KEY_W-1:0] k, res_t r);
    row_t w;
    w = req_row(f, c, k, 1);
    w.typed = 1'b1;
    w.res = r;
    return w;
  endfunction

  function automatic row_t cfg_row(row_kind_e kind, logic [31:0] v);
    row_t w;
    w = req_row(FUNC_LOCK, '0, '0, 0);
    w.kind = kind;
    w.wdata = v;
    return w;
  endfunction

  // append one row to the directed table
  function automatic void add_row(row_t w);
    dir_rows = {dir_rows, w};
  endfunction

  function automatic void check_field(string nm, int unsigned e, int unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, e, a);
      fail_cnt++;
    end
  endfunction

  // offer one word, record its expected result on acceptance
  task automatic send_req(req_t r, bit typed, res_t tres);
    res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = r;
    do @(posedge clk_i); while (!in_ready_o);
    pred = apply_request(r);
    due_results = {due_results, (typed ? tres : pred)};
    @(negedge clk_i);
  endtask

  // stop offering and let every outstanding result drain
  task automatic drain();
    in_valid_i = 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // register write, setup then access phase, also mirrored into the model
  task automatic write_reg(logic idx, logic [31:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == REG_LOCAL_CLIENT) local_id = v[CLIENT_W-1:0];
    else keys_limit = v[KEYS_W-1:0];
  endtask

  task automatic run_random(int unsigned items, int unsigned s_idle,
                            int unsigned r_stall, int unsigned lk_pct);
    send_idle_pct = s_idle;
    stall_pct     = r_stall;
    lock_pct      = lk_pct;
    repeat (items) send_req(draw_request(), 1'b0, '0);
  endtask

  // result receiver: random stalls plus a long hold-off when one is set
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i = 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result checker
  initial begin
    res_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h", $time, out_data_o);
          fail_cnt++;
        end else begin
          e = due_results[0];
          due_results.delete(0);
          check_field("status", e.status, out_data_o.status);
          check_field("local_granted", e.local_granted, out_data_o.local_granted);
          check_field("local_released", e.local_released, out_data_o.local_released);
          check_field("holder_valid", e.holder_valid, out_data_o.holder_valid);
          check_field("holder_client", e.holder_client, out_data_o.holder_client);
          check_field("waiting_count", e.waiting_count, out_data_o.waiting_count);
        end
      end
    end
  end

  // main sequence
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    fail_cnt      = 0;
    hold_cycles   = 0;
    send_idle_pct = 9;
    stall_pct     = 66;
    lock_pct      = 50;
    local_id      = '0;
    keys_limit    = KEYS_IN_USE_RST;
    for (int k = 0; k < KEY_COUNT; k++) begin
      ring_head[k] = '0;
      ring_len[k]  = '0;
      for (int p = 0; p < QUEUE_DEPTH; p++) waiter_ring[k][p] = '0;
    end

    // directed rows, reset defaults first
    add_row(typed_row(FUNC_UNLOCK, 8'h00, 6'd0, '{ST_EMPTY, 0, 0, 0, 0, 0}));
    add_row(typed_row(FUNC_LOCK, 8'h00, 6'd63, '{ST_OK, 1, 0, 1, 8'h00, 1}));
    add_row(typed_row(FUNC_LOCK, 8'hFF, 6'd63, '{ST_OK, 0, 0, 1, 8'h00, 2}));
    add_row(typed_row(FUNC_UNLOCK, 8'hFF, 6'd63,
                      '{ST_MISMATCH, 0, 0, 1, 8'h00, 2}));
    add_row(typed_row(FUNC_UNLOCK, 8'h00, 6'd63, '{ST_OK, 0, 1, 1, 8'hFF, 1}));
    add_row(typed_row(FUNC_UNLOCK, 8'hFF, 6'd63, '{ST_OK, 0, 0, 0, 8'h00, 0}));
    // one key in use, local client at its top id
    add_row(cfg_row(ROW_SET_LOCAL, 32'hFF));
    add_row(cfg_row(ROW_SET_KEYS, 32'd1));
    add_row(typed_row(FUNC_LOCK, 8'hFF, 6'd1, '{ST_BAD_KEY, 0, 0, 0, 0, 0}));
    add_row(typed_row(FUNC_LOCK, 8'hFF, 6'd0, '{ST_OK, 1, 0, 1, 8'hFF, 1}));
    // repeated lock by the holder, then hand-over back to itself
    add_row(req_row(FUNC_LOCK, 8'hFF, 6'd0, 1));
    add_row(req_row(FUNC_LOCK, 8'h07, 6'd0, 1));
    add_row(req_row(FUNC_UNLOCK, 8'hFF, 6'd0, 1));
    // fill the queue, then overflow it
    add_row(req_row(FUNC_LOCK, 8'h3C, 6'd0, 14));
    add_row(typed_row(FUNC_LOCK, 8'h81, 6'd0, '{ST_FULL, 0, 0, 1, 8'hFF, 16}));
    // no keys in use
    add_row(cfg_row(ROW_SET_KEYS, 32'd0));
    add_row(typed_row(FUNC_LOCK, 8'h00, 6'd0, '{ST_BAD_KEY, 0, 0, 0, 0, 0}));
    add_row(cfg_row(ROW_SET_KEYS, 32'd64));
    add_row(cfg_row(ROW_SET_LOCAL, 32'h3C));
    add_row(req_row(FUNC_UNLOCK, 8'h07, 6'd0, 1));
    add_row(req_row(FUNC_UNLOCK, 8'hFF, 6'd0, 1));
    add_row(req_row(FUNC_UNLOCK, 8'h07, 6'd0, 1));

    // reset
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_REQ: begin
          repeat (dir_rows[i].rep) send_req(dir_rows[i].req, dir_rows[i].typed,
                                            dir_rows[i].res);
        end
        ROW_SET_LOCAL: begin
          drain();
          write_reg(REG_LOCAL_CLIENT, dir_rows[i].wdata);
        end
        default: begin
          drain();
          write_reg(REG_KEYS_IN_USE, dir_rows[i].wdata);
        end
      endcase
    end
    drain();

    // random: sender mostly busy, receiver mostly stalled
    write_reg(REG_LOCAL_CLIENT, 32'h00);
    write_reg(REG_KEYS_IN_USE, 32'd64);
    run_random(240, 9, 66, 60);
    drain();

    // random: one key in use, sender mostly idle
    write_reg(REG_LOCAL_CLIENT, 32'hFF);
    write_reg(REG_KEYS_IN_USE, 32'd1);
    run_random(240, 66, 9, 40);
    drain();

    // random: no idling, with a long receiver hold-off at the start
    write_reg(REG_LOCAL_CLIENT, 32'($urandom_range(CLIENT_COUNT - 1)));
    write_reg(REG_KEYS_IN_USE, 32'($urandom_range(KEY_COUNT, 2)));
    hold_cycles = 300;
    run_random(240, 0, 0, 50);
    drain();

    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
